// ===== sv/pcsrq_pkg.sv =====
// ============================================================================
// pcsrq_pkg
// Shared types and constants of the per-column sorted refill queue.
// ============================================================================
package pcsrq_pkg;

    localparam int MAX_COLUMNS     = 8;
    localparam int ROWS_PER_COLUMN = 16;

    localparam int COL_IDX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_IDX_W   = $clog2(ROWS_PER_COLUMN);
    localparam int FILL_W      = $clog2(ROWS_PER_COLUMN + 1);
    localparam int STORE_DEPTH = MAX_COLUMNS * ROWS_PER_COLUMN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PEND_W      = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] NUM_COLUMNS_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_COLUMN = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_INS      = 3'd1,
        S_INS_LAST = 3'd2,
        S_POP      = 3'd3,
        S_DONE     = 3'd4
    } t_back_state;

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] ptype;
        logic [3:0] pcolor;
    } t_entry;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        t_op                  op;
        logic [COL_IDX_W-1:0] col;
        logic [FILL_W-1:0]    fill;
        t_entry               entry;
        t_status              status;
        logic                 column_empty;
        logic                 any_pending;
    } t_job;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_IDX_W-1:0] col,
                                                  input logic [ROW_IDX_W-1:0] pos);
        addr_of = ADDR_W'(col) * ADDR_W'(ROWS_PER_COLUMN) + ADDR_W'(pos);
    endfunction

endpackage

// ===== sv/pcsrq_ram.sv =====
// ============================================================================
// pcsrq_ram
// Generic one-write, one-read RAM with registered read data.
// ============================================================================
module pcsrq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pcsrq_front.sv =====
// ============================================================================
// pcsrq_front
// Accepts request beats, checks them against the fill counts and classifies them.
// ============================================================================
module pcsrq_front import pcsrq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_num_columns,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [3:0] i_column,
    input  logic [3:0] i_row,
    input  logic [3:0] i_piece_type,
    input  logic [3:0] i_piece_color,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [FILL_W-1:0] r_fill [MAX_COLUMNS];
    logic [PEND_W-1:0] r_pending;
    logic [PEND_W-1:0] n_pending;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] fill_cur;
    logic [COL_IDX_W-1:0] col_idx;
    logic col_ok;
    logic fill_we;
    logic accept;
    t_cmd cmd;

    assign cmd        = t_cmd'(i_cmd);
    assign col_idx    = i_column[COL_IDX_W-1:0];
    assign fill_cur   = r_fill[col_idx];
    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_push     = accept;

    always_comb begin
        col_ok = ({1'b0, i_column} < {1'b0, i_num_columns}) &&
                 ({1'b0, i_column} < 5'(MAX_COLUMNS));
        n_pending          = r_pending;
        n_fill             = fill_cur;
        fill_we            = 1'b0;
        o_job.op           = OP_NONE;
        o_job.col          = col_idx;
        o_job.fill         = fill_cur;
        o_job.entry.row    = i_row;
        o_job.entry.ptype  = i_piece_type;
        o_job.entry.pcolor = i_piece_color;
        o_job.status       = ST_OK;
        o_job.column_empty = 1'b0;
        case (cmd)
            CMD_ADD: begin
                if (!col_ok) begin
                    o_job.status = ST_BAD_COLUMN;
                end else if (fill_cur >= FILL_W'(ROWS_PER_COLUMN)) begin
                    o_job.status = ST_FULL;
                end else begin
                    o_job.op  = OP_INSERT;
                    n_fill    = fill_cur + FILL_W'(1);
                    n_pending = r_pending + PEND_W'(1);
                    fill_we   = 1'b1;
                end
            end
            CMD_POP: begin
                if (!col_ok) begin
                    o_job.status = ST_BAD_COLUMN;
                end else if (fill_cur == '0) begin
                    o_job.status = ST_EMPTY;
                end else begin
                    o_job.op  = OP_REMOVE;
                    n_fill    = fill_cur - FILL_W'(1);
                    n_pending = r_pending - PEND_W'(1);
                    fill_we   = 1'b1;
                end
            end
            CMD_QUERY: begin
                if (!col_ok) begin
                    o_job.status = ST_BAD_COLUMN;
                end else begin
                    o_job.column_empty = (fill_cur == '0);
                end
            end
            default: begin
            end
        endcase
        o_job.any_pending = (n_pending != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '{default: '0};
            r_pending <= '0;
        end else if (accept) begin
            r_pending <= n_pending;
            if (fill_we) begin
                r_fill[col_idx] <= n_fill;
            end
        end
    end

endmodule

// ===== sv/pcsrq_queue.sv =====
// ============================================================================
// pcsrq_queue
// Short FIFO of classified requests between the front and the back.
// ============================================================================
module pcsrq_queue import pcsrq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
        ptr_inc = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/pcsrq_back.sv =====
// ============================================================================
// pcsrq_back
// Carries out inserts and removals on the entry RAM and holds the result beat.
// ============================================================================
module pcsrq_back import pcsrq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [3:0] o_out_row,
    output logic [3:0] o_out_type,
    output logic [3:0] o_out_color,
    output logic       o_column_empty,
    output logic       o_any_pending
);

    t_back_state r_state;
    t_back_state n_state;
    t_job        r_job;
    t_entry      r_pop_entry;
    logic [ROW_IDX_W-1:0] r_k;
    logic [ROW_IDX_W-1:0] n_k;

    logic       r_out_valid;
    logic [1:0] r_status;
    logic [3:0] r_out_row;
    logic [3:0] r_out_type;
    logic [3:0] r_out_color;
    logic       r_column_empty;
    logic       r_any_pending;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry            rd;

    logic job_load;
    logic pop_cap;
    logic out_load;
    logic out_free;
    logic shift_on;
    logic more_pop;

    assign rd       = t_entry'(ram_rdata);
    assign out_free = !r_out_valid || !i_out_stall;
    assign shift_on = (rd.row >= r_job.entry.row);
    assign more_pop = (FILL_W'(r_k) + FILL_W'(1)) < r_job.fill;

    pcsrq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.op)
                        OP_INSERT: n_state = (i_job.fill == '0) ? S_INS_LAST : S_INS;
                        OP_REMOVE: n_state = S_POP;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INS: begin
                if (shift_on) begin
                    n_state = (r_k == '0) ? S_INS_LAST : S_INS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS_LAST: n_state = S_DONE;
            S_POP:      n_state = more_pop ? S_POP : S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM ports, index update and load strobes.
    always_comb begin
        o_pop     = 1'b0;
        job_load  = 1'b0;
        pop_cap   = 1'b0;
        out_load  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = rd;
        n_k       = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop    = 1'b1;
                    job_load = 1'b1;
                    if (i_job.op == OP_INSERT && i_job.fill != '0) begin
                        ram_re    = 1'b1;
                        n_k       = ROW_IDX_W'(i_job.fill - FILL_W'(1));
                        ram_raddr = addr_of(i_job.col, n_k);
                    end else if (i_job.op == OP_REMOVE) begin
                        ram_re    = 1'b1;
                        n_k       = '0;
                        ram_raddr = addr_of(i_job.col, '0);
                    end
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(r_job.col, r_k + ROW_IDX_W'(1));
                if (shift_on) begin
                    ram_wdata = rd;
                    if (r_k != '0) begin
                        ram_re    = 1'b1;
                        n_k       = r_k - ROW_IDX_W'(1);
                        ram_raddr = addr_of(r_job.col, n_k);
                    end
                end else begin
                    ram_wdata = r_job.entry;
                end
            end
            S_INS_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(r_job.col, '0);
                ram_wdata = r_job.entry;
            end
            S_POP: begin
                if (r_k == '0) begin
                    pop_cap = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_of(r_job.col, r_k - ROW_IDX_W'(1));
                    ram_wdata = rd;
                end
                if (more_pop) begin
                    ram_re    = 1'b1;
                    n_k       = r_k + ROW_IDX_W'(1);
                    ram_raddr = addr_of(r_job.col, n_k);
                end
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (job_load) begin
            r_job <= i_job;
        end
        if (pop_cap) begin
            r_pop_entry <= rd;
        end
        if (out_load) begin
            r_status       <= r_job.status;
            r_column_empty <= r_job.column_empty;
            r_any_pending  <= r_job.any_pending;
            if (r_job.op == OP_REMOVE) begin
                r_out_row   <= r_pop_entry.row;
                r_out_type  <= r_pop_entry.ptype;
                r_out_color <= r_pop_entry.pcolor;
            end else begin
                r_out_row   <= '0;
                r_out_type  <= '0;
                r_out_color <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_row      = r_out_row;
    assign o_out_type     = r_out_type;
    assign o_out_color    = r_out_color;
    assign o_column_empty = r_column_empty;
    assign o_any_pending  = r_any_pending;

endmodule

// ===== sv/per_column_sorted_refill_queue_unit.sv =====
// ============================================================================
// per_column_sorted_refill_queue_unit
// Per-column sorted lists of empty-cell records with add, pop and query.
// ============================================================================
// How to use this block:
// Requests arrive as beats on the input channel (i_in_valid / o_in_stall) and
// each request produces exactly one result beat on the output channel
// (o_out_valid / i_out_stall), in request order. The num_columns register is
// written through i_cfg_we / i_cfg_data, by the user only while the block is
// idle; the block itself does not enforce this. The front stage checks the
// column and its fill count when the beat is accepted and updates the counts
// at once; the request then waits in a two-entry queue for the back stage,
// which does the RAM work. A query, an error or an unused command does no RAM
// work; a pop moves each remaining record of the column down one place, and
// an add moves up each record whose row is not below the new one. The back
// stage moves one record per cycle through the single read and single write
// port of the entry RAM, and finishes one request before it takes the next.
// Reset clears the fill counts, the pending total, the queue and the result
// valid flag and sets num_columns to 8; the entry RAM is not cleared, since
// only entries below a column's fill count are ever read.
// While the receiver stalls, the result beat holds; the back stage finishes the
// next request and waits, and the front keeps taking beats until the queue
// is full, at which point o_in_stall rises.
module per_column_sorted_refill_queue_unit import pcsrq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [3:0] i_column,
    input  logic [3:0] i_row,
    input  logic [3:0] i_piece_type,
    input  logic [3:0] i_piece_color,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [3:0] o_out_row,
    output logic [3:0] o_out_type,
    output logic [3:0] o_out_color,
    output logic       o_column_empty,
    output logic       o_any_pending
);

    // Number of columns in use; columns at or above it are rejected.
    logic [3:0] r_num_columns;

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic front_push;
    t_job front_job;
    t_job q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_columns <= NUM_COLUMNS_RESET;
        end else if (i_cfg_we) begin
            r_num_columns <= i_cfg_data;
        end
    end

    // The front classifies each request and owns the fill counts and total.
    pcsrq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_num_columns (r_num_columns),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_piece_type  (i_piece_type),
        .i_piece_color (i_piece_color),
        .i_q_full      (q_full),
        .o_push        (front_push),
        .o_job         (front_job)
    );

    // The queue decouples classification from the RAM sequencer.
    pcsrq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    // The back shifts the sorted list in RAM and presents the result beat.
    pcsrq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_row      (o_out_row),
        .o_out_type     (o_out_type),
        .o_out_color    (o_out_color),
        .o_column_empty (o_column_empty),
        .o_any_pending  (o_any_pending)
    );

endmodule
